@@ rtl/core/tlf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants of the text line filter
// request payload types, status codes and front-to-back queue entry
// ----------------------------------------------------------------------------
package tlf_pkg;

    localparam int LINE_BYTES_DEF = 511;
    localparam int COUNT_FIELD_INDEX_DEF = 9;
    localparam int STORE_DEPTH = 512;
    localparam int ADDR_W = 9;
    localparam int LEN_W = 10;
    localparam logic [32:0] MAG_LIMIT = 33'h1_0000_0000 >> 1;

    localparam logic [1:0] ST_KEPT = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       object_end;
    } in_item_t;

    typedef struct packed {
        logic [63:0] line_word;
        logic [3:0]  valid_bytes;
        logic [1:0]  line_status;
        logic        line_last;
    } out_item_t;

    // one finished line handed from front to back
    typedef struct packed {
        logic [1:0]      status;   // kept or error code
        logic            keep;     // emit anything at all
        logic [LEN_W-1:0] length;  // stored bytes
        logic            bank;     // store half holding the line
    } line_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PRIME,
        BK_SEND
    } back_state_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

endpackage

@@ rtl/core/tlf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_ram: generic single-write, single-read ram
// registered read data
// ----------------------------------------------------------------------------
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/tlf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_front: byte intake and line parser
// stores line bytes, parses the count field, judges the line at its end
// ----------------------------------------------------------------------------
module tlf_front #(
    parameter int LINE_BYTES = tlf_pkg::LINE_BYTES_DEF,
    parameter int COUNT_FIELD_INDEX = tlf_pkg::COUNT_FIELD_INDEX_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  tlf_pkg::in_item_t       in_item,
    output logic                    in_stall,
    input  logic [31:0]             threshold,
    output logic                    st_we,
    output logic [tlf_pkg::ADDR_W:0] st_waddr,
    output logic [7:0]              st_wdata,
    output logic                    job_push,
    output tlf_pkg::line_job_t      job,
    input  logic                    job_full,
    input  logic                    bank_busy
);

    localparam logic [3:0] FIELD_IDX = 4'(COUNT_FIELD_INDEX > 15 ? 15 : COUNT_FIELD_INDEX);
    localparam logic IDX_REACHABLE = COUNT_FIELD_INDEX <= 15;

    logic [tlf_pkg::LEN_W-1:0] len_reg;
    logic [3:0]  fcnt_reg;
    logic        inf_reg;
    logic [32:0] acc_reg;
    logic        neg_reg, dig_reg, stop_reg, ovf_reg, long_reg;
    logic        bank_reg;

    logic [7:0] c;
    logic       is_nl, fin, take, blank, first, at_field, is_digit;
    logic [36:0] prod;
    logic [32:0] acc_next;
    logic       stop_next, neg_next, dig_next, ovf_next, long_next, inf_next;
    logic [3:0] fcnt_next;
    logic       present, bad;
    logic signed [33:0] value, thr;

    assign c = in_item.text_byte;
    assign is_nl = c == tlf_pkg::CH_NL;
    assign fin = is_nl || in_item.object_end;
    // a line end needs a queue slot and a free store half
    assign in_stall = fin && (job_full || bank_busy);
    assign take = in_valid && !in_stall;

    assign blank = tlf_pkg::is_blank(c);
    assign first = !inf_reg;
    assign at_field = IDX_REACHABLE && fcnt_reg == FIELD_IDX && !stop_reg;
    assign is_digit = c >= tlf_pkg::CH_ZERO && c <= tlf_pkg::CH_NINE;
    assign prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + 37'(c - tlf_pkg::CH_ZERO);

    always_comb
    begin
        acc_next = acc_reg;
        stop_next = stop_reg;
        neg_next = neg_reg;
        dig_next = dig_reg;
        ovf_next = ovf_reg;
        fcnt_next = fcnt_reg;
        inf_next = inf_reg;
        long_next = long_reg;
        if (!is_nl)
        begin
            if (32'(len_reg) >= 32'(LINE_BYTES))
            begin
                long_next = 1'b1;
            end
            if (blank)
            begin
                if (inf_reg)
                begin
                    if (IDX_REACHABLE && fcnt_reg == FIELD_IDX)
                    begin
                        stop_next = 1'b1;
                    end
                    if (fcnt_reg != 4'd15)
                    begin
                        fcnt_next = fcnt_reg + 4'd1;
                    end
                    inf_next = 1'b0;
                end
            end
            else
            begin
                inf_next = 1'b1;
                if (at_field)
                begin
                    if (first && c == tlf_pkg::CH_MINUS)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (first && c == tlf_pkg::CH_PLUS)
                    begin
                        neg_next = neg_reg;
                    end
                    else if (is_digit)
                    begin
                        dig_next = 1'b1;
                        if (!ovf_reg)
                        begin
                            if (prod > 37'(tlf_pkg::MAG_LIMIT))
                            begin
                                ovf_next = 1'b1;
                                acc_next = tlf_pkg::MAG_LIMIT + 33'd1;
                            end
                            else
                            begin
                                acc_next = prod[32:0];
                            end
                        end
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
        end
    end

    // judgment uses the state after this byte
    assign present = stop_next || (inf_next && IDX_REACHABLE && fcnt_next == FIELD_IDX);
    assign value = neg_next ? -$signed({1'b0, acc_next}) : $signed({1'b0, acc_next});
    assign thr = 34'(signed'(threshold));
    assign bad = !present || !dig_next || ovf_next ||
                 (neg_next ? acc_next > tlf_pkg::MAG_LIMIT
                           : acc_next > tlf_pkg::MAG_LIMIT - 33'd1);

    logic stored;
    assign stored = !is_nl && 32'(len_reg) < 32'(LINE_BYTES);
    assign st_we = take && stored;
    assign st_waddr = {bank_reg, len_reg[tlf_pkg::ADDR_W-1:0]};
    assign st_wdata = c;

    assign job_push = take && fin;
    always_comb
    begin
        job.bank = bank_reg;
        job.length = len_reg + tlf_pkg::LEN_W'(stored);
        if (long_next)
        begin
            job.status = tlf_pkg::ST_LONG;
            job.keep = 1'b1;
        end
        else if (bad)
        begin
            job.status = tlf_pkg::ST_BAD;
            job.keep = 1'b1;
        end
        else
        begin
            job.status = tlf_pkg::ST_KEPT;
            job.keep = !(value < thr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            fcnt_reg <= '0;
            inf_reg <= 1'b0;
            acc_reg <= '0;
            {neg_reg, dig_reg, stop_reg, ovf_reg, long_reg} <= '0;
            bank_reg <= 1'b0;
        end
        else if (take)
        begin
            if (fin)
            begin
                len_reg <= '0;
                fcnt_reg <= '0;
                inf_reg <= 1'b0;
                acc_reg <= '0;
                {neg_reg, dig_reg, stop_reg, ovf_reg, long_reg} <= '0;
                bank_reg <= !bank_reg;
            end
            else
            begin
                len_reg <= len_reg + tlf_pkg::LEN_W'(stored);
                fcnt_reg <= fcnt_next;
                inf_reg <= inf_next;
                acc_reg <= acc_next;
                {neg_reg, dig_reg, stop_reg, ovf_reg, long_reg} <=
                    {neg_next, dig_next, stop_next, ovf_next, long_next};
            end
        end
    end

endmodule

@@ rtl/core/tlf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_queue: two-entry queue of finished line jobs
// sits between parser and emitter
// ----------------------------------------------------------------------------
module tlf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tlf_pkg::line_job_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output tlf_pkg::line_job_t rdata
);

    tlf_pkg::line_job_t ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rdata = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/core/tlf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_back: result emitter
// reads a stored line eight bytes per word, or sends a status result
// ----------------------------------------------------------------------------
module tlf_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    input  tlf_pkg::line_job_t       job,
    output logic                     job_pop,
    output logic [tlf_pkg::ADDR_W:0] rd_addr,
    input  logic [7:0]               rd_data,
    output logic                     bank_active,
    output logic                     active_bank,
    output logic                     out_valid,
    output tlf_pkg::out_item_t       out_item,
    input  logic                     out_stall
);

    tlf_pkg::back_state_t state_reg, state_next;
    logic [tlf_pkg::LEN_W-1:0] pos_reg, pos_next;   // next byte to read
    logic [tlf_pkg::LEN_W-1:0] len_reg;
    logic        bank_reg;
    logic [63:0] word_reg, word_next;
    logic [3:0]  k_reg, k_next;
    logic        rdv_reg, rdv_next;                 // read data in flight
    logic [tlf_pkg::LEN_W-1:0] rpos_reg, rpos_next; // position of that data
    logic        ov_reg, ov_next;
    tlf_pkg::out_item_t oi_reg, oi_next;
    logic        load;

    assign out_valid = ov_reg;
    assign out_item = oi_reg;
    assign rd_addr = {bank_reg, pos_reg[tlf_pkg::ADDR_W-1:0]};
    assign bank_active = state_reg != tlf_pkg::BK_IDLE;
    assign active_bank = bank_reg;
    assign load = job_pop && job.keep && job.status == tlf_pkg::ST_KEPT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlf_pkg::BK_IDLE;
            ov_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            rdv_reg <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        word_reg <= word_next;
        k_reg <= k_next;
        rpos_reg <= rpos_next;
        oi_reg <= oi_next;
        if (load)
        begin
            len_reg <= job.length;
            bank_reg <= job.bank;
        end
    end

    always_comb
    begin
        logic       slot;
        logic       hold;
        logic [7:0] b;
        logic [tlf_pkg::LEN_W:0] total;
        state_next = state_reg;
        pos_next = pos_reg;
        word_next = word_reg;
        k_next = k_reg;
        rdv_next = 1'b0;
        rpos_next = rpos_reg;
        ov_next = ov_reg && out_stall;
        oi_next = oi_reg;
        job_pop = 1'b0;
        slot = !ov_reg || !out_stall;
        hold = 1'b0;
        total = {1'b0, len_reg} + 11'd1;
        b = 8'h00;
        case (state_reg)
            tlf_pkg::BK_IDLE:
            begin
                if (job_valid && slot)
                begin
                    job_pop = 1'b1;
                    if (job.keep && job.status != tlf_pkg::ST_KEPT)
                    begin
                        ov_next = 1'b1;
                        oi_next = '{line_word: '0, valid_bytes: 4'd0,
                                    line_status: job.status, line_last: 1'b1};
                    end
                    else if (job.keep)
                    begin
                        state_next = tlf_pkg::BK_PRIME;
                    end
                end
            end
            tlf_pkg::BK_PRIME:
            begin
                pos_next = '0;
                word_next = '0;
                k_next = '0;
                state_next = tlf_pkg::BK_SEND;
            end
            tlf_pkg::BK_SEND:
            begin
                // one byte per cycle via registered ram read unless stalled
                b = rpos_reg < len_reg ? rd_data : tlf_pkg::CH_NL;
                if (rdv_reg)
                begin
                    word_next[k_reg[2:0]*8 +: 8] = b;
                    k_next = k_reg + 4'd1;
                end
                if (rdv_reg && (k_next == 4'd8 || {1'b0, rpos_reg} + 11'd1 == total))
                begin
                    if (slot)
                    begin
                        ov_next = 1'b1;
                        oi_next = '{line_word: word_next, valid_bytes: k_next,
                                    line_status: tlf_pkg::ST_KEPT,
                                    line_last: {1'b0, rpos_reg} + 11'd1 == total};
                        word_next = '0;
                        k_next = '0;
                        if ({1'b0, rpos_reg} + 11'd1 == total)
                        begin
                            state_next = tlf_pkg::BK_IDLE;
                        end
                    end
                    else
                    begin
                        // hold: drop the byte in flight and reread this one
                        word_next = word_reg;
                        k_next = k_reg;
                        hold = 1'b1;
                        pos_next = rpos_reg;
                    end
                end
                if (state_next == tlf_pkg::BK_SEND && !hold)
                begin
                    if ({1'b0, pos_reg} < total)
                    begin
                        rdv_next = 1'b1;
                        rpos_next = pos_reg;
                        pos_next = pos_reg + tlf_pkg::LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = tlf_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/text_line_field_threshold_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_field_threshold_filter_top: line filter on a counted text field
// parses lines of a text object and forwards those whose count passes
// ----------------------------------------------------------------------------
// usage
//   in channel: one text byte per request, object_end marks the last byte
//   of the object. the front parser takes one byte per cycle and writes it
//   into one half of a double-buffered 1 KiB line store
//   out channel: kept lines come out as 64-bit words, first byte in bits
//   7:0, with a newline appended; dropped lines that cannot be judged give
//   one status request (too long or malformed count)
//   throughput: one byte per cycle inside a line; at a line end the front
//   hands a job to a two-entry queue and flips store halves. the emitter
//   reads one byte per cycle through the ram's registered port while the
//   out channel does not stall; the front stalls at a line end while a job
//   is still queued or the other half is being emitted
//   stall: a stalled out request holds; the emitter pauses and rereads the
//   pending byte, the front keeps filling the other half
//   reset: all parse state, queue and emitter clear; threshold resets to 0;
//   store contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module text_line_field_threshold_filter_top #(
    parameter int LINE_BYTES = tlf_pkg::LINE_BYTES_DEF,
    parameter int COUNT_FIELD_INDEX = tlf_pkg::COUNT_FIELD_INDEX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tlf_pkg::in_item_t  in_data,
    output logic               in_stall,
    output logic               out_valid,
    output tlf_pkg::out_item_t out_data,
    input  logic               out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] thr_reg;

    // store write side (front) and read side (back)
    logic                     st_we;
    logic [tlf_pkg::ADDR_W:0] st_waddr, st_raddr;
    logic [7:0]               st_wdata, st_rdata;

    tlf_pkg::line_job_t job_in, job_out;
    logic job_push, job_full, job_pop, job_ne;
    logic bank_active, active_bank, bank_busy;

    assign pready = 1'b1;
    assign prdata = thr_reg;

    // paddr is one bit: byte address 0 selects the threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == tlf_pkg::REG_THRESHOLD[0])
        begin
            thr_reg <= pwdata;
        end
    end

    // the half about to be reused must not still be waiting or emitting;
    // a queued job, or the emitter still on the other half, blocks the line end
    assign bank_busy = job_ne || bank_active;

    tlf_front #(
        .LINE_BYTES(LINE_BYTES),
        .COUNT_FIELD_INDEX(COUNT_FIELD_INDEX)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_item(in_data), .in_stall(in_stall),
        .threshold(thr_reg),
        .st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
        .job_push(job_push), .job(job_in), .job_full(job_full),
        .bank_busy(bank_busy && (active_bank != st_waddr[tlf_pkg::ADDR_W] || job_ne))
    );

    tlf_ram #(.WIDTH(8), .DEPTH(2 * tlf_pkg::STORE_DEPTH)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    tlf_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(job_push), .wdata(job_in), .full(job_full),
        .pop(job_pop), .not_empty(job_ne), .rdata(job_out)
    );

    tlf_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_ne), .job(job_out), .job_pop(job_pop),
        .rd_addr(st_raddr), .rd_data(st_rdata),
        .bank_active(bank_active), .active_bank(active_bank),
        .out_valid(out_valid), .out_item(out_data), .out_stall(out_stall)
    );

endmodule

@@ rtl/core/tlf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_checker: port-level checks of the line filter
// bound to the top level
// ----------------------------------------------------------------------------
module tlf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input tlf_pkg::out_item_t out_data,
    input logic               out_stall
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled out request changed");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.line_status != tlf_pkg::ST_KEPT |->
        out_data.line_last && out_data.valid_bytes == 4'd0)
        else $error("status request malformed");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.line_status == tlf_pkg::ST_KEPT |->
        out_data.valid_bytes != 4'd0 && out_data.valid_bytes <= 4'd8)
        else $error("bad byte count");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.line_status == tlf_pkg::ST_KEPT && !out_data.line_last |->
        out_data.valid_bytes == 4'd8)
        else $error("short word before line end");

endmodule

bind text_line_field_threshold_filter_top tlf_checker u_tlf_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
    .out_data(out_data), .out_stall(out_stall)
);
